@@ hw/rtl/zps_pkg.sv @@
// ----------------------------------------------------------------------------
// zps_pkg
// Shared types and constants of the cart-table preview control step:
// item payloads, item kinds, register indexes, datapath term and
// destination codes, and the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package zps_pkg;

    // Default preview window depth
    localparam int ZPS_WINDOW_DEPTH = 256;

    // Field and datapath widths
    localparam int SIG_W      = 32;   // Q16.16 signal
    localparam int COEF_W     = 48;   // Q24.24 coefficient
    localparam int OPND_W     = 33;   // signal operand, room for a negated minimum
    localparam int SPLIT_W    = 24;   // coefficient split point for the partial products
    localparam int PP_LO_W    = 58;   // {0, coef[23:0]} x operand
    localparam int PP_HI_W    = 57;   // coef[47:24] x operand
    localparam int ACC_W      = 96;   // accumulator, 40 fractional bits
    localparam int DROP_W     = 24;   // fraction bits dropped when rounding to Q16.16
    localparam int CFG_W      = 48;   // widest configuration register
    localparam int CFG_IDX_W  = 3;
    localparam int PLEN_W     = 9;    // preview_length register width

    // One in Q24.24, used to lift a Q16.16 signal to 40 fractional bits
    localparam logic signed [COEF_W-1:0] COEF_ONE = 48'sd16777216;

    typedef enum logic [1:0] {
        KIND_GAIN  = 2'd0,
        KIND_REF   = 2'd1,
        KIND_STEP  = 2'd2,
        KIND_STATE = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_TIME      = 3'd0,
        REG_HALF_STEP_SQ   = 3'd1,
        REG_SIXTH_STEP_CU  = 3'd2,
        REG_HEIGHT_FACTOR  = 3'd3,
        REG_K_POSITION     = 3'd4,
        REG_K_VELOCITY     = 3'd5,
        REG_K_ACCELERATION = 3'd6,
        REG_PREVIEW_LENGTH = 3'd7
    } reg_idx_t;

    // Product terms the datapath can form: coefficient x signal
    typedef enum logic [3:0] {
        TERM_KP      = 4'd0,   // k_position x (-p)
        TERM_KV      = 4'd1,   // k_velocity x (-v)
        TERM_KA      = 4'd2,   // k_acceleration x (-a)
        TERM_PREV    = 4'd3,   // gain[i] x ref[i]
        TERM_LIFT_P  = 4'd4,   // 1 x p
        TERM_DT_V    = 4'd5,   // dt x v
        TERM_HS_A    = 4'd6,   // dt^2/2 x a
        TERM_SC_J    = 4'd7,   // dt^3/6 x jerk
        TERM_LIFT_V  = 4'd8,   // 1 x v
        TERM_DT_A    = 4'd9,   // dt x a
        TERM_HS_J    = 4'd10,  // dt^2/2 x jerk
        TERM_LIFT_A  = 4'd11,  // 1 x a
        TERM_DT_J    = 4'd12,  // dt x jerk
        TERM_LIFT_NP = 4'd13,  // 1 x new p
        TERM_HF_NA   = 4'd14   // height_factor x new a
    } term_t;

    // Where a finished sum is written after rounding
    typedef enum logic [2:0] {
        DEST_JERK = 3'd0,
        DEST_POS  = 3'd1,
        DEST_VEL  = 3'd2,
        DEST_ACC  = 3'd3,
        DEST_ZMP  = 3'd4
    } dest_t;

    typedef struct packed {
        logic [1:0]               kind;
        logic [7:0]               index;
        logic signed [COEF_W-1:0] gain_word;
        logic signed [SIG_W-1:0]  sample_value;
        logic signed [SIG_W-1:0]  init_position;
        logic signed [SIG_W-1:0]  init_velocity;
        logic signed [SIG_W-1:0]  init_acceleration;
        logic signed [SIG_W-1:0]  init_zmp;
    } in_item_t;

    typedef struct packed {
        logic signed [SIG_W-1:0] com_position;
        logic signed [SIG_W-1:0] com_velocity;
        logic signed [SIG_W-1:0] com_acceleration;
        logic signed [SIG_W-1:0] zmp_out;
        logic signed [SIG_W-1:0] jerk_out;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic  valid;    // issue one product term
        logic  take;     // an item is accepted this cycle
        logic  commit;   // copy new state to state and result registers
        term_t term;
        logic  first;    // first term of a sum: restart the accumulator
        logic  last;     // last term of a sum: round and write back
        dest_t dest;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic  wb;       // a sum is being rounded and written back
        dest_t dest;
    } stat_t;

endpackage

@@ hw/rtl/zps_chan_if.sv @@
// ----------------------------------------------------------------------------
// zps_chan_if
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface zps_chan_if #(
    parameter type PAYLOAD_T = logic
);
    logic     valid;
    logic     ready;
    PAYLOAD_T payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

@@ hw/rtl/zmp_preview_control_step_core.sv @@
// ----------------------------------------------------------------------------
// zmp_preview_control_step_core
// A step item forms a jerk sum of feedback and L preview terms, where
// L is the clamped preview length; the single multiply-accumulate pipeline
// takes one term a cycle and the dependent sums wait for its writeback.
// Load and set-state items are taken in idle; no item is taken until a step commits.
// Reset: state, configuration and handshakes clear at once; the window
// memories are undefined until written.
// ----------------------------------------------------------------------------
module zmp_preview_control_step_core #(
    parameter int WINDOW_DEPTH = zps_pkg::ZPS_WINDOW_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    zps_chan_if.sink                      items,
    zps_chan_if.source                    results,
    input  logic                          cfg_we,
    input  logic [zps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [zps_pkg::CFG_W-1:0]     cfg_data
);
    import zps_pkg::*;

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    cmd_t              cmd;
    stat_t             stat;
    logic [AW-1:0]     rd_addr;
    logic [PLEN_W-1:0] preview_length;
    in_item_t          item;
    out_item_t         result;

    assign item            = items.payload;
    assign results.payload = result;

    zps_ctrl #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (items.valid),
        .item_kind      (item.kind),
        .item_ready     (items.ready),
        .res_valid      (results.valid),
        .res_ready      (results.ready),
        .preview_length (preview_length),
        .stat           (stat),
        .cmd            (cmd),
        .rd_addr        (rd_addr)
    );

    zps_dpath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .rd_addr        (rd_addr),
        .item           (item),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .stat           (stat),
        .preview_length (preview_length),
        .result         (result)
    );

`ifndef ASSERT_OFF
    // No writeback while the block is open for a new item
    a_wb_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.wb |-> !items.ready)
        else $error("sum written back while idle");

    // No term issued while the block is open for a new item
    a_term_busy: assert property (@(posedge clk) disable iff (!rst_n)
        items.ready |-> !cmd.valid)
        else $error("term issued while idle");

    // A new result appears only after a commit
    a_result_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(cmd.commit))
        else $error("result raised without commit");
`endif

endmodule

@@ hw/rtl/zps_ctrl.sv @@
// ----------------------------------------------------------------------------
// zps_ctrl
// Step sequencer: takes items, issues the product terms of each sum to the
// datapath in order, waits for results that later sums depend on, and
// hands the finished step to the output register.
// ----------------------------------------------------------------------------
module zps_ctrl #(
    parameter int WINDOW_DEPTH = zps_pkg::ZPS_WINDOW_DEPTH,
    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
    localparam int LW = $clog2(WINDOW_DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  logic [1:0]                   item_kind,
    output logic                         item_ready,
    output logic                         res_valid,
    input  logic                         res_ready,
    input  logic [zps_pkg::PLEN_W-1:0]   preview_length,
    input  zps_pkg::stat_t               stat,
    output zps_pkg::cmd_t                cmd,
    output logic [AW-1:0]                rd_addr
);
    import zps_pkg::*;

    localparam logic [3:0] FB_LAST  = 4'd2;
    localparam logic [3:0] INT_LAST = 4'd8;
    localparam logic [3:0] ZMP_LAST = 4'd1;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_FB     = 9'b000000010,
        S_PREV   = 9'b000000100,
        S_WAIT_J = 9'b000001000,
        S_INT    = 9'b000010000,
        S_WAIT_A = 9'b000100000,
        S_ZMP    = 9'b001000000,
        S_WAIT_Z = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t        state_reg, state_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic          res_valid_reg, res_valid_next;
    logic [LW-1:0] len;

    // Clamp the preview length to the window
    assign len = (32'(preview_length) > WINDOW_DEPTH) ? LW'(WINDOW_DEPTH)
                                                      : LW'(preview_length);

    assign rd_addr   = idx_reg[AW-1:0];
    assign res_valid = res_valid_reg;

    // Sequence the terms of each sum
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        res_valid_next = res_valid_reg;
        cmd            = '0;
        item_ready     = 1'b0;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.take = 1'b1;
                    if (kind_t'(item_kind) == KIND_STEP)
                    begin
                        cnt_next   = '0;
                        state_next = S_FB;
                    end
                end
            end

            // State feedback terms of the jerk sum
            S_FB:
            begin
                cmd.valid = 1'b1;
                cmd.dest  = DEST_JERK;
                cmd.first = (cnt_reg == 4'd0);
                case (cnt_reg)
                    4'd0:    cmd.term = TERM_KP;
                    4'd1:    cmd.term = TERM_KV;
                    default: cmd.term = TERM_KA;
                endcase
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == FB_LAST)
                begin
                    idx_next = '0;
                    if (len == '0)
                    begin
                        cmd.last   = 1'b1;
                        state_next = S_WAIT_J;
                    end
                    else
                    begin
                        state_next = S_PREV;
                    end
                end
            end

            // One preview term a cycle
            S_PREV:
            begin
                cmd.valid = 1'b1;
                cmd.dest  = DEST_JERK;
                cmd.term  = TERM_PREV;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == len - 1'b1)
                begin
                    cmd.last   = 1'b1;
                    state_next = S_WAIT_J;
                end
            end

            S_WAIT_J:
            begin
                if (stat.wb && stat.dest == DEST_JERK)
                begin
                    cnt_next   = '0;
                    state_next = S_INT;
                end
            end

            // Integrator sums for position, velocity and acceleration
            S_INT:
            begin
                cmd.valid = 1'b1;
                case (cnt_reg)
                    4'd0:
                    begin
                        cmd.term  = TERM_LIFT_P;
                        cmd.dest  = DEST_POS;
                        cmd.first = 1'b1;
                    end
                    4'd1:
                    begin
                        cmd.term = TERM_DT_V;
                        cmd.dest = DEST_POS;
                    end
                    4'd2:
                    begin
                        cmd.term = TERM_HS_A;
                        cmd.dest = DEST_POS;
                    end
                    4'd3:
                    begin
                        cmd.term = TERM_SC_J;
                        cmd.dest = DEST_POS;
                        cmd.last = 1'b1;
                    end
                    4'd4:
                    begin
                        cmd.term  = TERM_LIFT_V;
                        cmd.dest  = DEST_VEL;
                        cmd.first = 1'b1;
                    end
                    4'd5:
                    begin
                        cmd.term = TERM_DT_A;
                        cmd.dest = DEST_VEL;
                    end
                    4'd6:
                    begin
                        cmd.term = TERM_HS_J;
                        cmd.dest = DEST_VEL;
                        cmd.last = 1'b1;
                    end
                    4'd7:
                    begin
                        cmd.term  = TERM_LIFT_A;
                        cmd.dest  = DEST_ACC;
                        cmd.first = 1'b1;
                    end
                    default:
                    begin
                        cmd.term = TERM_DT_J;
                        cmd.dest = DEST_ACC;
                        cmd.last = 1'b1;
                    end
                endcase
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == INT_LAST)
                begin
                    state_next = S_WAIT_A;
                end
            end

            S_WAIT_A:
            begin
                if (stat.wb && stat.dest == DEST_ACC)
                begin
                    cnt_next   = '0;
                    state_next = S_ZMP;
                end
            end

            // ZMP from the new position and acceleration
            S_ZMP:
            begin
                cmd.valid = 1'b1;
                cmd.dest  = DEST_ZMP;
                if (cnt_reg == 4'd0)
                begin
                    cmd.term  = TERM_LIFT_NP;
                    cmd.first = 1'b1;
                end
                else
                begin
                    cmd.term = TERM_HF_NA;
                    cmd.last = 1'b1;
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == ZMP_LAST)
                begin
                    state_next = S_WAIT_Z;
                end
            end

            S_WAIT_Z:
            begin
                if (stat.wb && stat.dest == DEST_ZMP)
                begin
                    state_next = S_DONE;
                end
            end

            // Hold until the result register is free, then commit
            S_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    cmd.commit     = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

@@ hw/rtl/zps_dpath.sv @@
// ----------------------------------------------------------------------------
// zps_dpath
// Datapath: configuration registers, gain and reference memories, state
// registers, and a pipelined multiply-accumulate unit that forms one
// coefficient x signal term a cycle, rounds finished sums to Q16.16 and
// writes them back.
// ----------------------------------------------------------------------------
module zps_dpath #(
    parameter int WINDOW_DEPTH = zps_pkg::ZPS_WINDOW_DEPTH,
    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  zps_pkg::cmd_t                 cmd,
    input  logic [AW-1:0]                 rd_addr,
    input  zps_pkg::in_item_t             item,
    input  logic                          cfg_we,
    input  logic [zps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [zps_pkg::CFG_W-1:0]     cfg_data,
    output zps_pkg::stat_t                stat,
    output logic [zps_pkg::PLEN_W-1:0]    preview_length,
    output zps_pkg::out_item_t            result
);
    import zps_pkg::*;

    // Round to nearest (ties up), drop the extra fraction, saturate
    function automatic logic signed [SIG_W-1:0] round_sat(input logic [ACC_W-1:0] x);
        logic [ACC_W-1:0]        r;
        logic [ACC_W-DROP_W-1:0] q;
        r = x + (ACC_W'(1) << (DROP_W - 1));
        q = r[ACC_W-1:DROP_W];
        if ((&q[ACC_W-DROP_W-1:SIG_W-1]) || !(|q[ACC_W-DROP_W-1:SIG_W-1]))
        begin
            return q[SIG_W-1:0];
        end
        else if (q[ACC_W-DROP_W-1])
        begin
            return {1'b1, {(SIG_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(SIG_W-1){1'b1}}};
        end
    endfunction

    // Configuration registers
    logic [COEF_W-2:0]        step_time_reg;
    logic [COEF_W-2:0]        half_sq_reg;
    logic [COEF_W-2:0]        sixth_cu_reg;
    logic signed [COEF_W-1:0] height_reg;
    logic signed [COEF_W-1:0] kp_reg;
    logic signed [COEF_W-1:0] kv_reg;
    logic signed [COEF_W-1:0] ka_reg;
    logic [PLEN_W-1:0]        plen_reg;

    // Controller state and the sums of the step in progress; the ZMP of a
    // set-state item is never read out, as every step forms its ZMP afresh
    logic signed [SIG_W-1:0] pos_reg, vel_reg, accel_reg;
    logic signed [SIG_W-1:0] jerk_new_reg, pos_new_reg, vel_new_reg;
    logic signed [SIG_W-1:0] accel_new_reg, zmp_new_reg;
    out_item_t               result_reg;

    // Window memories
    logic signed [COEF_W-1:0] gain_mem [WINDOW_DEPTH];
    logic signed [SIG_W-1:0]  ref_mem  [WINDOW_DEPTH];
    logic signed [COEF_W-1:0] gain_rd_reg;
    logic signed [SIG_W-1:0]  ref_rd_reg;

    // MAC pipeline
    logic                      s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    term_t                     s1_term_reg;
    logic                      s1_first_reg, s2_first_reg, s3_first_reg;
    logic                      s1_last_reg, s2_last_reg, s3_last_reg, s4_last_reg;
    dest_t                     s1_dest_reg, s2_dest_reg, s3_dest_reg, s4_dest_reg;
    logic signed [COEF_W-1:0]  coef;
    logic signed [OPND_W-1:0]  opnd;
    logic signed [SPLIT_W:0]   coef_lo;
    logic signed [COEF_W-SPLIT_W-1:0] coef_hi;
    logic signed [PP_LO_W-1:0] pp_lo_next, pp_lo_reg;
    logic signed [PP_HI_W-1:0] pp_hi_next, pp_hi_reg;
    logic [ACC_W-1:0]          term_next, term_reg;
    logic [ACC_W-1:0]          acc_next, acc_reg;
    logic signed [SIG_W-1:0]   rounded;
    logic                      item_write, write_in_range;
    kind_t                     item_kind;

    assign item_kind      = kind_t'(item.kind);
    assign item_write     = cmd.take;
    assign write_in_range = (32'(item.index) < WINDOW_DEPTH);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_time_reg <= '0;
            half_sq_reg   <= '0;
            sixth_cu_reg  <= '0;
            height_reg    <= '0;
            kp_reg        <= '0;
            kv_reg        <= '0;
            ka_reg        <= '0;
            plen_reg      <= PLEN_W'(1);
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_STEP_TIME:      step_time_reg <= cfg_data[COEF_W-2:0];
                REG_HALF_STEP_SQ:   half_sq_reg   <= cfg_data[COEF_W-2:0];
                REG_SIXTH_STEP_CU:  sixth_cu_reg  <= cfg_data[COEF_W-2:0];
                REG_HEIGHT_FACTOR:  height_reg    <= cfg_data;
                REG_K_POSITION:     kp_reg        <= cfg_data;
                REG_K_VELOCITY:     kv_reg        <= cfg_data;
                REG_K_ACCELERATION: ka_reg        <= cfg_data;
                REG_PREVIEW_LENGTH: plen_reg      <= cfg_data[PLEN_W-1:0];
                default:            plen_reg      <= plen_reg;
            endcase
        end
    end

    assign preview_length = plen_reg;

    // Window memories: write on load items, read every cycle
    always_ff @(posedge clk)
    begin
        if (item_write && item_kind == KIND_GAIN && write_in_range)
        begin
            gain_mem[AW'(item.index)] <= item.gain_word;
        end
        gain_rd_reg <= gain_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (item_write && item_kind == KIND_REF && write_in_range)
        begin
            ref_mem[AW'(item.index)] <= item.sample_value;
        end
        ref_rd_reg <= ref_mem[rd_addr];
    end

    // Select the coefficient and signal of the term in stage one
    always_comb
    begin
        coef = '0;
        opnd = '0;
        case (s1_term_reg)
            TERM_KP:
            begin
                coef = kp_reg;
                opnd = -OPND_W'(pos_reg);
            end
            TERM_KV:
            begin
                coef = kv_reg;
                opnd = -OPND_W'(vel_reg);
            end
            TERM_KA:
            begin
                coef = ka_reg;
                opnd = -OPND_W'(accel_reg);
            end
            TERM_PREV:
            begin
                coef = gain_rd_reg;
                opnd = OPND_W'(ref_rd_reg);
            end
            TERM_LIFT_P:
            begin
                coef = COEF_ONE;
                opnd = OPND_W'(pos_reg);
            end
            TERM_DT_V:
            begin
                coef = $signed({1'b0, step_time_reg});
                opnd = OPND_W'(vel_reg);
            end
            TERM_HS_A:
            begin
                coef = $signed({1'b0, half_sq_reg});
                opnd = OPND_W'(accel_reg);
            end
            TERM_SC_J:
            begin
                coef = $signed({1'b0, sixth_cu_reg});
                opnd = OPND_W'(jerk_new_reg);
            end
            TERM_LIFT_V:
            begin
                coef = COEF_ONE;
                opnd = OPND_W'(vel_reg);
            end
            TERM_DT_A:
            begin
                coef = $signed({1'b0, step_time_reg});
                opnd = OPND_W'(accel_reg);
            end
            TERM_HS_J:
            begin
                coef = $signed({1'b0, half_sq_reg});
                opnd = OPND_W'(jerk_new_reg);
            end
            TERM_LIFT_A:
            begin
                coef = COEF_ONE;
                opnd = OPND_W'(accel_reg);
            end
            TERM_DT_J:
            begin
                coef = $signed({1'b0, step_time_reg});
                opnd = OPND_W'(jerk_new_reg);
            end
            TERM_LIFT_NP:
            begin
                coef = COEF_ONE;
                opnd = OPND_W'(pos_new_reg);
            end
            TERM_HF_NA:
            begin
                coef = height_reg;
                opnd = OPND_W'(accel_new_reg);
            end
            default:
            begin
                coef = '0;
                opnd = '0;
            end
        endcase
    end

    // Two partial products: low coefficient half unsigned, high half signed
    assign coef_lo    = $signed({1'b0, coef[SPLIT_W-1:0]});
    assign coef_hi    = coef[COEF_W-1:SPLIT_W];
    assign pp_lo_next = coef_lo * opnd;
    assign pp_hi_next = coef_hi * opnd;

    // Recombine the partial products at full width
    assign term_next = {{(ACC_W-PP_HI_W-SPLIT_W){pp_hi_reg[PP_HI_W-1]}}, pp_hi_reg,
                        {SPLIT_W{1'b0}}}
                     + {{(ACC_W-PP_LO_W){pp_lo_reg[PP_LO_W-1]}}, pp_lo_reg};

    assign acc_next = s3_first_reg ? term_reg : (acc_reg + term_reg);

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        s1_term_reg  <= cmd.term;
        s1_first_reg <= cmd.first;
        s1_last_reg  <= cmd.last;
        s1_dest_reg  <= cmd.dest;

        pp_lo_reg    <= pp_lo_next;
        pp_hi_reg    <= pp_hi_next;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_dest_reg  <= s1_dest_reg;

        term_reg     <= term_next;
        s3_first_reg <= s2_first_reg;
        s3_last_reg  <= s2_last_reg;
        s3_dest_reg  <= s2_dest_reg;

        if (s3_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        s4_last_reg <= s3_last_reg;
        s4_dest_reg <= s3_dest_reg;
    end

    assign rounded   = round_sat(acc_reg);
    assign stat.wb   = s4_valid_reg && s4_last_reg;
    assign stat.dest = s4_dest_reg;

    // Write back finished sums
    always_ff @(posedge clk)
    begin
        if (stat.wb)
        begin
            case (s4_dest_reg)
                DEST_JERK: jerk_new_reg  <= rounded;
                DEST_POS:  pos_new_reg   <= rounded;
                DEST_VEL:  vel_new_reg   <= rounded;
                DEST_ACC:  accel_new_reg <= rounded;
                DEST_ZMP:  zmp_new_reg   <= rounded;
                default:   zmp_new_reg   <= zmp_new_reg;
            endcase
        end
    end

    // Controller state: load on set-state items, advance on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            vel_reg   <= '0;
            accel_reg <= '0;
        end
        else if (item_write && item_kind == KIND_STATE)
        begin
            pos_reg   <= item.init_position;
            vel_reg   <= item.init_velocity;
            accel_reg <= item.init_acceleration;
        end
        else if (cmd.commit)
        begin
            pos_reg   <= pos_new_reg;
            vel_reg   <= vel_new_reg;
            accel_reg <= accel_new_reg;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            result_reg.com_position     <= pos_new_reg;
            result_reg.com_velocity     <= vel_new_reg;
            result_reg.com_acceleration <= accel_new_reg;
            result_reg.zmp_out          <= zmp_new_reg;
            result_reg.jerk_out         <= jerk_new_reg;
        end
    end

    assign result = result_reg;

endmodule
